FILE: hw/rtl/dtsp_pkg.sv
// Shared constants and a helper function for the decimal time string parser.
package dtsp_pkg;

  localparam int FRACTION_DIGITS_DEF = 6;
  localparam int SECONDS_WIDTH_DEF   = 64;

  // Fixed field widths of the stream items.
  localparam int CHAR_W      = 8;
  localparam int STATUS_W    = 1;
  localparam int SECONDS_W   = 64;
  localparam int MICRO_W     = 21;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 88;

  // Character codes.
  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

  // Status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK    = 1'b0;
  localparam logic [STATUS_W-1:0] STATUS_ERROR = 1'b1;

  // Power of ten, evaluated at elaboration only.
  function automatic logic [63:0] pow10(int n);
    logic [63:0] r;
    r = 64'd1;
    for (int i = 0; i < n; i++) begin
      r = r * 64'd10;
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/decimal_time_string_parser_unit.sv
// Top level of the decimal time string parser: character stream in, time value out.
// Result path: a NUL item accepted into the input register moves on into the result register,
// where its result item becomes valid.
// Throughput: one character per cycle; a NUL only waits while the result register is full
// and not being read.
// Reset: asynchronous, active low; clears both valid flags and the parse state.
module decimal_time_string_parser_unit #(
  parameter int FRACTION_DIGITS = dtsp_pkg::FRACTION_DIGITS_DEF,
  parameter int SECONDS_WIDTH   = dtsp_pkg::SECONDS_WIDTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // tdata: character[7:0]
  input  logic [dtsp_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // tdata: status[0], seconds[64:1], microseconds[85:65], zero fill[87:86]
  output logic [dtsp_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i
);

  localparam int ACC_W  = SECONDS_WIDTH - 1;
  localparam int PROD_W = SECONDS_WIDTH + 3;
  localparam int FRAC_W = $clog2(10 ** FRACTION_DIGITS);
  localparam int CNT_W  = $clog2(FRACTION_DIGITS + 1);
  localparam int IDX_W  = (FRACTION_DIGITS > 1) ? $clog2(FRACTION_DIGITS) : 1;
  localparam int NEG_W  = FRAC_W + dtsp_pkg::MICRO_W;
  localparam logic [PROD_W-1:0] LIMIT = (PROD_W'(1) << (SECONDS_WIDTH - 1)) - PROD_W'(1);

  localparam logic [2:0] PH_LEAD   = 3'd0;
  localparam logic [2:0] PH_SIGNED = 3'd1;
  localparam logic [2:0] PH_INT    = 3'd2;
  localparam logic [2:0] PH_POINT  = 3'd3;
  localparam logic [2:0] PH_FRAC   = 3'd4;
  localparam logic [2:0] PH_TRAIL  = 3'd5;
  localparam logic [2:0] PH_ERROR  = 3'd6;

  // Input register.
  logic                        in_valid_q;
  logic [dtsp_pkg::CHAR_W-1:0] char_q;

  // Parse state.
  logic [2:0]        phase_q, phase_d;
  logic              negative_q, negative_d;
  logic [ACC_W-1:0]  whole_q, whole_d;
  logic              overflow_q, overflow_d;
  logic [FRAC_W-1:0] frac_q, frac_d;
  logic [CNT_W-1:0]  count_q, count_d;

  // Result register.
  logic                             out_valid_q, out_valid_d;
  logic [dtsp_pkg::OUT_TDATA_W-1:0] out_data_q, out_data_d;

  logic advance;
  logic out_free;
  logic is_nul;
  logic is_ws;
  logic is_digit;
  logic [3:0] digit;
  logic [PROD_W-1:0] whole_next;
  logic digit_overflows;
  logic [FRAC_W-1:0] place [2**IDX_W];
  logic [FRAC_W+3:0] frac_step;
  logic result_ok;
  logic [dtsp_pkg::SECONDS_W-1:0] seconds_val;
  logic [NEG_W-1:0] frac_signed;
  logic [dtsp_pkg::MICRO_W-1:0] micro_val;

  // Weight of the next fraction digit, so that the fraction is always held padded.
  for (genvar g = 0; g < 2**IDX_W; g++) begin : g_place
    if (g < FRACTION_DIGITS) begin : g_used
      assign place[g] = FRAC_W'(dtsp_pkg::pow10(FRACTION_DIGITS - 1 - g));
    end else begin : g_unused
      assign place[g] = '0;
    end
  end

  assign out_free = !out_valid_q || m_axis_tready_i;
  assign is_nul   = (char_q == dtsp_pkg::CH_NUL);
  // A character only stalls when it is a NUL and the result register is still full.
  assign advance  = in_valid_q && (!is_nul || out_free);
  assign s_axis_tready_o = !in_valid_q || advance;

  assign is_ws    = (char_q == dtsp_pkg::CH_SPACE) ||
                    ((char_q >= dtsp_pkg::CH_TAB) && (char_q <= dtsp_pkg::CH_CR));
  assign is_digit = (char_q >= dtsp_pkg::CH_ZERO) && (char_q <= dtsp_pkg::CH_NINE);
  assign digit    = char_q[3:0];

  assign whole_next = {3'b000, whole_q, 1'b0} + {1'b0, whole_q, 3'b000} + PROD_W'(digit);
  assign digit_overflows = overflow_q || (whole_next > LIMIT);
  assign frac_step = {4'd0, frac_q} + (FRAC_W + 4)'(digit * place[count_q[IDX_W-1:0]]);

  assign result_ok = ((phase_q == PH_INT) || (phase_q == PH_POINT) ||
                      (phase_q == PH_FRAC) || (phase_q == PH_TRAIL)) && !overflow_q;
  assign seconds_val = negative_q ? (dtsp_pkg::SECONDS_W'(0) - dtsp_pkg::SECONDS_W'(whole_q))
                                  : dtsp_pkg::SECONDS_W'(whole_q);
  assign frac_signed = negative_q ? (NEG_W'(0) - NEG_W'(frac_q)) : NEG_W'(frac_q);
  assign micro_val   = frac_signed[dtsp_pkg::MICRO_W-1:0];

  always_comb begin
    phase_d    = phase_q;
    negative_d = negative_q;
    whole_d    = whole_q;
    overflow_d = overflow_q;
    frac_d     = frac_q;
    count_d    = count_q;
    out_data_d = out_data_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;

    if (advance) begin
      if (is_nul) begin
        out_valid_d = 1'b1;
        if (result_ok) begin
          out_data_d = {2'b00, micro_val, seconds_val, dtsp_pkg::STATUS_OK};
        end else begin
          out_data_d = {2'b00, dtsp_pkg::MICRO_W'(0), dtsp_pkg::SECONDS_W'(0),
                        dtsp_pkg::STATUS_ERROR};
        end
        // The next character starts a fresh string.
        phase_d    = PH_LEAD;
        negative_d = 1'b0;
        whole_d    = '0;
        overflow_d = 1'b0;
        frac_d     = '0;
        count_d    = '0;
      end else begin
        unique case (phase_q) inside
          PH_LEAD: begin
            if (is_ws) begin
              phase_d = PH_LEAD;
            end else if (char_q == dtsp_pkg::CH_PLUS) begin
              phase_d = PH_SIGNED;
            end else if (char_q == dtsp_pkg::CH_MINUS) begin
              negative_d = 1'b1;
              phase_d    = PH_SIGNED;
            end else if (is_digit) begin
              phase_d = PH_INT;
              if (digit_overflows) overflow_d = 1'b1;
              else whole_d = whole_next[ACC_W-1:0];
            end else begin
              phase_d = PH_ERROR;
            end
          end
          PH_SIGNED, PH_INT: begin
            if (is_digit) begin
              phase_d = PH_INT;
              if (digit_overflows) overflow_d = 1'b1;
              else whole_d = whole_next[ACC_W-1:0];
            end else if ((phase_q == PH_INT) && is_ws) begin
              phase_d = PH_TRAIL;
            end else if ((phase_q == PH_INT) && (char_q == dtsp_pkg::CH_POINT)) begin
              phase_d = PH_POINT;
            end else begin
              phase_d = PH_ERROR;
            end
          end
          PH_POINT, PH_FRAC: begin
            if (is_digit) begin
              if (count_q >= CNT_W'(FRACTION_DIGITS)) begin
                phase_d = PH_ERROR;
              end else begin
                frac_d  = frac_step[FRAC_W-1:0];
                count_d = count_q + CNT_W'(1);
                phase_d = PH_FRAC;
              end
            end else if (is_ws) begin
              phase_d = PH_TRAIL;
            end else begin
              phase_d = PH_ERROR;
            end
          end
          PH_TRAIL: begin
            if (!is_ws) phase_d = PH_ERROR;
          end
          default: begin
            phase_d = PH_ERROR;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      phase_q     <= PH_LEAD;
      negative_q  <= 1'b0;
      whole_q     <= '0;
      overflow_q  <= 1'b0;
      frac_q      <= '0;
      count_q     <= '0;
    end else begin
      if (s_axis_tready_o) in_valid_q <= s_axis_tvalid_i;
      out_valid_q <= out_valid_d;
      phase_q     <= phase_d;
      negative_q  <= negative_d;
      whole_q     <= whole_d;
      overflow_q  <= overflow_d;
      frac_q      <= frac_d;
      count_q     <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) char_q <= s_axis_tdata_i;
    out_data_q <= out_data_d;
  end

  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tvalid_o = out_valid_q;

endmodule

FILE: tb/tb_decimal_time_string_parser_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the decimal time string parser: predicts each result item and checks it.
module tb_decimal_time_string_parser_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // tdata: character[7:0]
  input  logic [dtsp_pkg::IN_TDATA_W-1:0]  s_tdata_i,
  input  logic                             s_tvalid_i,
  input  logic                             s_tready_i,
  // tdata: status[0], seconds[64:1], microseconds[85:65], zero fill[87:86]
  input  logic [dtsp_pkg::OUT_TDATA_W-1:0] m_tdata_i,
  input  logic                             m_tvalid_i,
  input  logic                             m_tready_i,
  output int                               mismatches_o,
  output int                               outstanding_o
);

  typedef enum logic [2:0] {
    PH_LEAD,
    PH_SIGNED,
    PH_INT,
    PH_POINT,
    PH_FRAC,
    PH_TRAIL,
    PH_ERROR
  } parse_phase_e;

  typedef struct packed {
    logic [dtsp_pkg::STATUS_W-1:0]  status;
    logic [dtsp_pkg::SECONDS_W-1:0] seconds;
    logic [dtsp_pkg::MICRO_W-1:0]   micro;
  } time_value_t;

  localparam logic [63:0] WHOLE_LIMIT = {64{1'b1}} >> (65 - dtsp_pkg::SECONDS_WIDTH_DEF);

  parse_phase_e phase;
  logic         negative;
  logic [63:0]  whole_acc;
  logic         whole_ovf;
  logic [19:0]  frac_acc;
  logic [3:0]   frac_count;
  time_value_t  time_q[$];
  int           mismatches;

  function automatic logic is_space(input logic [dtsp_pkg::CHAR_W-1:0] c);
    return c == dtsp_pkg::CH_SPACE || (c >= dtsp_pkg::CH_TAB && c <= dtsp_pkg::CH_CR);
  endfunction

  function automatic logic is_numeral(input logic [dtsp_pkg::CHAR_W-1:0] c);
    return c >= dtsp_pkg::CH_ZERO && c <= dtsp_pkg::CH_NINE;
  endfunction

  task automatic clear_parse();
    phase      = PH_LEAD;
    negative   = 1'b0;
    whole_acc  = '0;
    whole_ovf  = 1'b0;
    frac_acc   = '0;
    frac_count = '0;
  endtask

  // Once the integer would pass the seconds limit the flag sticks and the
  // accumulator is left alone.
  task automatic add_whole_digit(input logic [dtsp_pkg::CHAR_W-1:0] c);
    logic [63:0] d;
    d = 64'(c - dtsp_pkg::CH_ZERO);
    if (whole_ovf || whole_acc > (WHOLE_LIMIT - d) / 64'd10) begin
      whole_ovf = 1'b1;
    end else begin
      whole_acc = whole_acc * 64'd10 + d;
    end
  endtask

  task automatic add_frac_digit(input logic [dtsp_pkg::CHAR_W-1:0] c);
    if (frac_count >= dtsp_pkg::FRACTION_DIGITS_DEF) begin
      phase = PH_ERROR;
    end else begin
      frac_acc   = frac_acc * 20'd10 + 20'(c - dtsp_pkg::CH_ZERO);
      frac_count = frac_count + 4'd1;
      phase      = PH_FRAC;
    end
  endtask

  task automatic parse_char(input logic [dtsp_pkg::CHAR_W-1:0] c);
    time_value_t res;
    logic [63:0] frac;
    if (c == dtsp_pkg::CH_NUL) begin
      res = '0;
      res.status = dtsp_pkg::STATUS_ERROR;
      if (phase inside {PH_INT, PH_POINT, PH_FRAC, PH_TRAIL} && !whole_ovf) begin
        frac = 64'(frac_acc);
        for (int i = frac_count; i < dtsp_pkg::FRACTION_DIGITS_DEF; i++) begin
          frac = frac * 64'd10;
        end
        res.status  = dtsp_pkg::STATUS_OK;
        res.seconds = negative ? -whole_acc : whole_acc;
        res.micro   = negative ? -frac[dtsp_pkg::MICRO_W-1:0] : frac[dtsp_pkg::MICRO_W-1:0];
      end
      time_q.push_back(res);
      clear_parse();
    end else begin
      case (phase)
        PH_LEAD: begin
          if (is_space(c)) begin
          end else if (c == dtsp_pkg::CH_PLUS) begin
            phase = PH_SIGNED;
          end else if (c == dtsp_pkg::CH_MINUS) begin
            negative = 1'b1;
            phase    = PH_SIGNED;
          end else if (is_numeral(c)) begin
            add_whole_digit(c);
            phase = PH_INT;
          end else begin
            phase = PH_ERROR;
          end
        end
        PH_SIGNED: begin
          if (is_numeral(c)) begin
            add_whole_digit(c);
            phase = PH_INT;
          end else begin
            phase = PH_ERROR;
          end
        end
        PH_INT: begin
          if (is_numeral(c)) add_whole_digit(c);
          else if (is_space(c)) phase = PH_TRAIL;
          else if (c == dtsp_pkg::CH_POINT) phase = PH_POINT;
          else phase = PH_ERROR;
        end
        PH_POINT, PH_FRAC: begin
          if (is_numeral(c)) add_frac_digit(c);
          else if (is_space(c)) phase = PH_TRAIL;
          else phase = PH_ERROR;
        end
        PH_TRAIL: begin
          if (!is_space(c)) phase = PH_ERROR;
        end
        default: begin
          phase = PH_ERROR;
        end
      endcase
    end
  endtask

  task automatic check_result(input logic [dtsp_pkg::OUT_TDATA_W-1:0] d);
    time_value_t want;
    time_value_t got;
    got.status  = d[0];
    got.seconds = d[64:1];
    got.micro   = d[85:65];
    if (time_q.size() == 0) begin
      mismatches++;
      $display("%0t: unexpected result item, status %0d seconds %0d microseconds %0d",
               $time, got.status, $signed(got.seconds), $signed(got.micro));
      return;
    end
    want = time_q.pop_front();
    if (got.status !== want.status) begin
      mismatches++;
      $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
    end
    if (got.seconds !== want.seconds) begin
      mismatches++;
      $display("%0t: seconds expected %0d actual %0d", $time,
               $signed(want.seconds), $signed(got.seconds));
    end
    if (got.micro !== want.micro) begin
      mismatches++;
      $display("%0t: microseconds expected %0d actual %0d", $time,
               $signed(want.micro), $signed(got.micro));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_parse();
      time_q.delete();
      mismatches = 0;
      mismatches_o  <= 0;
      outstanding_o <= 0;
    end else begin
      if (s_tvalid_i && s_tready_i) parse_char(s_tdata_i);
      if (m_tvalid_i && m_tready_i) check_result(m_tdata_i);
      mismatches_o  <= mismatches;
      outstanding_o <= time_q.size();
    end
  end

endmodule

FILE: tb/tb_decimal_time_string_parser_unit.sv
`timescale 1ns / 100ps
// Testbench top for the decimal time string parser: clock, reset, character stimulus and verdict.
module tb_decimal_time_string_parser_unit;

  localparam int CHARS_PER_PHASE = 340;
  localparam int CYCLE_LIMIT     = 400000;

  logic                             clk      = 1'b0;
  logic                             rst_n    = 1'b0;
  logic [dtsp_pkg::IN_TDATA_W-1:0]  s_tdata  = '0;
  logic                             s_tvalid = 1'b0;
  logic                             s_tready;
  logic [dtsp_pkg::OUT_TDATA_W-1:0] m_tdata;
  logic                             m_tvalid;
  logic                             m_tready = 1'b0;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int chars_sent     = 0;
  int cycles         = 0;
  int mismatches;
  int outstanding;

  logic [dtsp_pkg::CHAR_W-1:0] text_q[$];
  string extreme_digits[5] = '{
    "9223372036854775807",
    "9223372036854775808",
    "0009223372036854775807",
    "99999999999999999999",
    "0"
  };

  decimal_time_string_parser_unit u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .m_axis_tdata_o (m_tdata),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready)
  );

  tb_decimal_time_string_parser_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .s_tdata_i    (s_tdata),
    .s_tvalid_i   (s_tvalid),
    .s_tready_i   (s_tready),
    .m_tdata_i    (m_tdata),
    .m_tvalid_i   (m_tvalid),
    .m_tready_i   (m_tready),
    .mismatches_o (mismatches),
    .outstanding_o(outstanding)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic logic [dtsp_pkg::CHAR_W-1:0] space_char();
    if ($urandom_range(1)) return dtsp_pkg::CH_SPACE;
    return dtsp_pkg::CH_TAB +
           dtsp_pkg::CHAR_W'($urandom_range(dtsp_pkg::CH_CR - dtsp_pkg::CH_TAB));
  endfunction

  function automatic logic [dtsp_pkg::CHAR_W-1:0] numeral_char();
    return dtsp_pkg::CH_ZERO + dtsp_pkg::CHAR_W'($urandom_range(9));
  endfunction

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endtask

  // Valid is only lowered inside an idle cycle, so it never drops between
  // two items sent back to back.
  task automatic push_char(input logic [dtsp_pkg::CHAR_W-1:0] c);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tdata  <= c;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic send_line();
    text_q.push_back(dtsp_pkg::CH_NUL);
    foreach (text_q[i]) push_char(text_q[i]);
    chars_sent += text_q.size();
    text_q.delete();
  endtask

  // Mostly well-formed strings with random content; some are corrupted and
  // some are plain noise.
  task automatic build_random_text();
    int kind;
    int pos;
    kind = $urandom_range(99);
    if (kind < 12) begin
      repeat ($urandom_range(1, 6)) begin
        text_q.push_back(dtsp_pkg::CHAR_W'($urandom_range(1, 255)));
      end
      return;
    end
    repeat ($urandom_range(2)) text_q.push_back(space_char());
    case ($urandom_range(2))
      1: text_q.push_back(dtsp_pkg::CH_PLUS);
      2: text_q.push_back(dtsp_pkg::CH_MINUS);
      default: ;
    endcase
    case ($urandom_range(9))
      0: add_text(extreme_digits[$urandom_range(4)]);
      1: repeat ($urandom_range(17, 21)) text_q.push_back(numeral_char());
      default: repeat ($urandom_range(1, 4)) text_q.push_back(numeral_char());
    endcase
    if ($urandom_range(1)) begin
      text_q.push_back(dtsp_pkg::CH_POINT);
      repeat ($urandom_range(7) == 7 ? 7 : $urandom_range(6)) text_q.push_back(numeral_char());
    end
    repeat ($urandom_range(2)) text_q.push_back(space_char());
    if (kind >= 82) begin
      pos = $urandom_range(text_q.size() - 1);
      case ($urandom_range(3))
        0: text_q[pos] = dtsp_pkg::CHAR_W'($urandom_range(1, 255));
        1: text_q.delete(pos);
        2: text_q.insert(pos, $urandom_range(1) ? dtsp_pkg::CH_POINT : dtsp_pkg::CH_MINUS);
        default: text_q.insert(pos, $urandom_range(1) ? space_char() : numeral_char());
      endcase
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_line();
    add_text("-7.");
    send_line();
    text_q.push_back(8'hFF);
    send_line();
    add_text("+");
    send_line();
    add_text("1.1234567");
    send_line();
    text_q.push_back(dtsp_pkg::CH_CR);
    add_text("3 ");
    send_line();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
        default: begin send_idle_pct = 24; recv_stall_pct = 24; end
      endcase
      while (chars_sent < (ph + 1) * CHARS_PER_PHASE) begin
        build_random_text();
        send_line();
      end
    end
    s_tvalid <= 1'b0;

    do @(posedge clk); while (outstanding != 0);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
